// ===== rtl/lrr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants for the ranged Lehmer generator.
// ----------------------------------------------------------------------------
package lrr_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned MultW = 29;
  localparam int unsigned ProdW = WordW + MultW;
  localparam int unsigned AccW  = WordW + 2;

  typedef logic        [WordW-1:0] word_t;
  typedef logic signed [WordW-1:0] sword_t;
  typedef logic        [AccW-1:0]  acc_t;
  typedef logic        [ProdW-1:0] prod_t;

  // func codes
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncDraw = 1'b1;

  localparam logic [MultW-1:0] LehmerMult = 29'd279470273;
  localparam word_t            LehmerMod  = 32'hFFFF_FFFB;
  // two's complement of the modulus at accumulator width
  localparam acc_t             NegMod     = 34'h3_0000_0005;
  localparam word_t            ResetState = 32'd1;

endpackage

// ===== rtl/lrr_if.sv =====
// ----------------------------------------------------------------------------
// lrr_in_if / lrr_out_if
// Valid/ready channels for draw requests and results.
// ----------------------------------------------------------------------------
interface lrr_in_if;
  import lrr_pkg::*;

  logic   valid;
  logic   ready;
  logic   func;
  word_t  seed_value;
  sword_t range_low;
  sword_t range_high;

  modport source (output valid, func, seed_value, range_low, range_high, input ready);
  modport sink   (input valid, func, seed_value, range_low, range_high, output ready);
endinterface

interface lrr_out_if;
  import lrr_pkg::*;

  logic   valid;
  logic   ready;
  sword_t drawn_value;
  word_t  state_after;
  logic   zero_range;

  modport source (output valid, drawn_value, state_after, zero_range, input ready);
  modport sink   (input valid, drawn_value, state_after, zero_range, output ready);
endinterface

// ===== rtl/lehmer_range_random.sv =====
// ----------------------------------------------------------------------------
// lehmer_range_random: Lehmer generator mod 2^32-5 with a ranged draw
// Load item: seed stored on accept, then output load. Draw item: multiply,
// two folds, reduce, 32 restoring divide steps on the shared adder, add low
// bound, output load; a zero range skips divide and add. A stalled result
// holds the block in its last step, one item at a time.
// Async active-low reset: state = 1, no result pending.
// ----------------------------------------------------------------------------
module lehmer_range_random (
  input logic       clk_i,
  input logic       rst_ni,
  lrr_in_if.sink    in_i,
  lrr_out_if.source out_o
);
  import lrr_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StFold1,
    StFold2,
    StReduce,
    StDiv,
    StAddLo,
    StFinish
  } state_e;

  state_e state_q;

  // generator state and working registers
  word_t      gen_q;
  prod_t      prod_q;
  acc_t       acc_q;
  word_t      lo_q;
  word_t      hi_q;
  word_t      range_q;
  word_t      dvd_q;     // dividend, shifted out MSB first
  word_t      rem_q;     // partial remainder, always below range
  logic [4:0] cnt_q;
  word_t      res_drawn_q;
  logic       res_flag_q;

  // output register
  logic   out_valid_q;
  sword_t out_drawn_q;
  word_t  out_state_q;
  logic   out_flag_q;

  // Shared adder: every arithmetic step after the multiply goes through it.
  acc_t  alu_a;
  acc_t  alu_b;
  acc_t  alu_sum;
  logic [WordW:0] div_shift;
  logic  out_free;

  assign div_shift = {rem_q, dvd_q[WordW-1]};
  assign alu_sum   = alu_a + alu_b;
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      StMul: begin
        // range = high - low, wrapped
        alu_a = {2'b00, hi_q};
        alu_b = {2'b00, ~lo_q} + acc_t'(1);
      end
      StFold1: begin
        // 2^32 == 5 (mod M): fold the upper product bits back in
        alu_a = {2'b00, prod_q[WordW-1:0]};
        alu_b = acc_t'({prod_q[ProdW-1:WordW], 2'b00}) + acc_t'(prod_q[ProdW-1:WordW]);
      end
      StFold2: begin
        alu_a = {2'b00, acc_q[WordW-1:0]};
        alu_b = acc_t'({acc_q[AccW-1:WordW], 2'b00}) + acc_t'(acc_q[AccW-1:WordW]);
      end
      StReduce: begin
        alu_a = acc_q;
        alu_b = NegMod;
      end
      StDiv: begin
        // trial subtract of the range
        alu_a = {1'b0, div_shift};
        alu_b = ~{2'b00, range_q} + acc_t'(1);
      end
      StAddLo: begin
        alu_a = {2'b00, rem_q};
        alu_b = {2'b00, lo_q};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign in_i.ready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gen_q       <= ResetState;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      // drop the result once it is taken, unless a new one loads this cycle
      if (out_valid_q && out_o.ready && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            lo_q <= word_t'(in_i.range_low);
            hi_q <= word_t'(in_i.range_high);
            if (in_i.func == FuncLoad) begin
              gen_q       <= in_i.seed_value;
              res_drawn_q <= '0;
              res_flag_q  <= 1'b0;
              state_q     <= StFinish;
            end else begin
              state_q <= StMul;
            end
          end
        end
        StMul: begin
          prod_q  <= prod_t'(gen_q) * prod_t'(LehmerMult);
          range_q <= alu_sum[WordW-1:0];
          state_q <= StFold1;
        end
        StFold1: begin
          acc_q   <= alu_sum;
          state_q <= StFold2;
        end
        StFold2: begin
          acc_q   <= alu_sum;
          state_q <= StReduce;
        end
        StReduce: begin
          // at most one subtract: the folded value stays below twice M
          priority if (acc_q >= {2'b00, LehmerMod}) begin
            gen_q <= alu_sum[WordW-1:0];
            dvd_q <= alu_sum[WordW-1:0];
          end else begin
            gen_q <= acc_q[WordW-1:0];
            dvd_q <= acc_q[WordW-1:0];
          end
          rem_q <= '0;
          cnt_q <= 5'(WordW - 1);
          if (range_q == '0) begin
            // zero range: hold the low bound and raise the flag
            res_drawn_q <= lo_q;
            res_flag_q  <= 1'b1;
            state_q     <= StFinish;
          end else begin
            res_flag_q <= 1'b0;
            state_q    <= StDiv;
          end
        end
        StDiv: begin
          // restoring step: keep the difference when it does not borrow
          if (!alu_sum[AccW-1]) begin
            rem_q <= alu_sum[WordW-1:0];
          end else begin
            rem_q <= div_shift[WordW-1:0];
          end
          dvd_q <= {dvd_q[WordW-2:0], 1'b0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            state_q <= StAddLo;
          end
        end
        StAddLo: begin
          res_drawn_q <= alu_sum[WordW-1:0];
          state_q     <= StFinish;
        end
        StFinish: begin
          // wait until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_drawn_q <= sword_t'(res_drawn_q);
            out_state_q <= gen_q;
            out_flag_q  <= res_flag_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drawn_value = out_drawn_q;
  assign out_o.state_after = out_state_q;
  assign out_o.zero_range  = out_flag_q;

endmodule

// ===== dv/lrr_scoreboard.sv =====
// ----------------------------------------------------------------------------
// lrr_scoreboard
// Passive checker for the ranged Lehmer generator. It tracks the generator
// state from accepted request items, predicts one result per item and compares
// every accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module lrr_scoreboard
  import lrr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lrr_in_if           in_mon_i,
  lrr_out_if          out_mon_i,
  output int unsigned mismatch_o,
  output int unsigned pending_o
);

  localparam logic [63:0] GenMult      = 64'd279470273;
  localparam logic [63:0] GenModulus   = 64'h0000_0000_FFFF_FFFB;
  localparam word_t       GenResetSeed = 32'd1;

  typedef struct packed {
    sword_t drawn;
    word_t  state;
    logic   zero_range;
  } draw_result_t;

  word_t        gen_state;
  draw_result_t expected_q[$];
  int unsigned  errors;

  // Multiply into 64 bits, then reduce modulo 2^32 - 5.
  function automatic word_t lehmer_advance(input word_t s);
    logic [63:0] prod;
    logic [63:0] folded;
    prod   = {32'd0, s} * GenMult;
    folded = prod % GenModulus;
    return folded[31:0];
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s differs, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    draw_result_t want;
    word_t        span;
    if (!rst_ni) begin
      gen_state = GenResetSeed;
      expected_q.delete();
      errors = 0;
    end else begin
      // Retire results before predicting, so a spurious result never
      // matches the item accepted at the same edge.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual drawn %h state %h flag %b",
                   $time, out_mon_i.drawn_value, out_mon_i.state_after,
                   out_mon_i.zero_range);
        end else begin
          want = expected_q.pop_front();
          check_field("drawn_value", want.drawn, out_mon_i.drawn_value);
          check_field("state_after", want.state, out_mon_i.state_after);
          check_field("zero_range", {31'd0, want.zero_range}, {31'd0, out_mon_i.zero_range});
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (in_mon_i.func == FuncLoad) begin
          gen_state       = in_mon_i.seed_value;
          want.drawn      = '0;
          want.zero_range = 1'b0;
        end else begin
          gen_state = lehmer_advance(gen_state);
          span      = in_mon_i.range_high - in_mon_i.range_low;
          if (span == '0) begin
            want.drawn      = in_mon_i.range_low;
            want.zero_range = 1'b1;
          end else begin
            want.drawn      = (gen_state % span) + word_t'(in_mon_i.range_low);
            want.zero_range = 1'b0;
          end
        end
        want.state = gen_state;
        expected_q.insert(expected_q.size(), want);
      end
    end
    mismatch_o <= errors;
    pending_o  <= expected_q.size();
  end

endmodule

// ===== dv/tb_lehmer_range_random.sv =====
// ----------------------------------------------------------------------------
// tb_lehmer_range_random
// Stimulus and verdict for the ranged Lehmer generator. A directed set covers
// bound extremes, equal and reversed bounds, zero and out-of-modulus seeds;
// random load/draw streams then run under four idle/stall phases while the
// scoreboard checks every result.
// ----------------------------------------------------------------------------
module tb_lehmer_range_random;
  import lrr_pkg::*;

  // Drain after the last result: longer than a draw takes end to end.
  localparam int unsigned DrainCycles   = 60;
  // Cycles without any item moving before the run is declared hung.
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ItemsPerPhase = 100;

  localparam sword_t SMin = 32'sh8000_0000;
  localparam sword_t SMax = 32'sh7FFF_FFFF;
  localparam sword_t Corners [4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1};

  logic clk_i;
  logic rst_ni;

  lrr_in_if  in_if ();
  lrr_out_if out_if ();

  int unsigned mismatch_count;
  int unsigned pending_count;

  // Idle/stall odds in percent; stall_pct is read by the ready driver at the
  // clock edge, so update it with a nonblocking assignment.
  int unsigned idle_pct;
  int unsigned stall_pct;

  int unsigned n_loads;
  int unsigned n_draws;
  int unsigned n_flat;
  int unsigned quiet_cycles;

  lehmer_range_random u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  lrr_scoreboard u_scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon_i   (in_if),
    .out_mon_i  (out_if),
    .mismatch_o (mismatch_count),
    .pending_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: drop ready at random according to the current phase.
  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, no item moved for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request item and hold it until the block takes it. While
  // idling, scramble the payload so that only valid qualifies it.
  task automatic send(input logic func, input word_t seed, input sword_t lo,
                      input sword_t hi);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid      <= 1'b0;
      in_if.func       <= 1'($urandom);
      in_if.seed_value <= $urandom;
      in_if.range_low  <= $urandom;
      in_if.range_high <= $urandom;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= func;
    in_if.seed_value <= seed;
    in_if.range_low  <= lo;
    in_if.range_high <= hi;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (func == FuncLoad) begin
      n_loads++;
    end else begin
      n_draws++;
      if (lo == hi) n_flat++;
    end
  endtask

  initial begin : stimulus
    logic   func;
    word_t  seed;
    sword_t lo;
    sword_t hi;
    // Hold the request channel at a known value from time zero.
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FuncLoad;
    in_if.seed_value = '0;
    in_if.range_low  = '0;
    in_if.range_high = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    n_loads          = 0;
    n_draws          = 0;
    n_flat           = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling. The first draw starts from the reset state.
    send(FuncDraw, 32'h0, 32'sd0, 32'sd10);
    send(FuncDraw, 32'h0, SMin, SMin);                 // equal bounds at the minimum
    send(FuncDraw, 32'hFFFF_FFFF, SMin, SMax);         // widest forward span
    send(FuncDraw, 32'h0, SMax, SMin);                 // reversed, wraps to a span of one
    send(FuncDraw, 32'h0, 32'sd0, SMin);               // span with only the top bit set
    send(FuncDraw, 32'h0, SMax, SMax);                 // equal bounds at the maximum
    send(FuncDraw, 32'h0, -32'sd1, 32'sd0);
    send(FuncDraw, 32'h0, 32'sd5, 32'sd3);             // reversed, near-full divisor
    send(FuncDraw, 32'h0, SMax, 32'sh8000_0010);       // sum overflows past the maximum
    send(FuncLoad, 32'h0, SMax, SMin);                 // zero seed locks the state
    send(FuncDraw, 32'hFFFF_FFFF, 32'sd0, 32'sd100);
    send(FuncDraw, 32'h0, -32'sd50, 32'sd50);
    send(FuncLoad, 32'hFFFF_FFFF, SMin, SMax);         // seed above the modulus
    send(FuncDraw, 32'h0, SMin, SMin + 32'sd1);
    send(FuncLoad, 32'hFFFF_FFFB, 32'sd0, 32'sd0);     // seed equal to the modulus
    send(FuncDraw, 32'h0, 32'sd0, 32'sd0);
    send(FuncLoad, 32'hFFFF_FFFA, -32'sd1, -32'sd1);   // largest in-range seed
    send(FuncDraw, 32'h0, SMin, SMax);
    send(FuncLoad, 32'h8000_0000, 32'sd1, 32'sd2);
    send(FuncDraw, 32'h5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
    send(FuncLoad, 32'h0000_0001, 32'sd0, 32'sd0);
    send(FuncDraw, 32'h0, -32'sd1000, -32'sd999);

    // Random part: mostly draws with varied bounds, a load now and then.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  = 80;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 80;
        end
        default: begin
          idle_pct  = 10;
          stall_pct <= 10;
        end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        func = ($urandom_range(9) == 0) ? FuncLoad : FuncDraw;
        case ($urandom_range(7))
          0:       seed = 32'hFFFF_FFFB + $urandom_range(4);
          1:       seed = ($urandom_range(9) == 0) ? 32'h0 : $urandom_range(15);
          default: seed = $urandom;
        endcase
        lo = $urandom;
        case ($urandom_range(9))
          0:       hi = lo;
          1, 2, 3: hi = lo + sword_t'($urandom_range(100, 1));
          4, 5:    hi = $urandom;
          6:       hi = lo - sword_t'($urandom_range(100, 1));
          7: begin
            lo = Corners[2'($urandom_range(3))];
            hi = Corners[2'($urandom_range(3))];
          end
          default: begin
            lo = sword_t'($urandom_range(200)) - 32'sd100;
            hi = lo + sword_t'($urandom);
          end
        endcase
        send(func, seed, lo, hi);
      end
    end
    in_if.valid <= 1'b0;
    stall_pct   <= 0;

    // Let the last accepted item register, then wait for every result and
    // drain a while longer to catch anything stray.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d load items and %0d draw items, %0d of them with equal bounds,",
             n_loads, n_draws, n_flat);
    $display("across phases of no idling, 80%% sender idle, 80%% result stall and 10%% both.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
